/* src/heartbeat_deadline_table_core_defines.svh */
// ----------------------------------------------------------------------------
// heartbeat deadline table assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef HEARTBEAT_DEADLINE_TABLE_CORE_DEFINES_SVH
`define HEARTBEAT_DEADLINE_TABLE_CORE_DEFINES_SVH

// property checked on every clock edge outside reset
`define HDT_ASSERT_RST(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("%m: assertion failed");

// property checked on every clock edge, reset included
`define HDT_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("%m: assertion failed");

`endif

/* src/hdt_pkg.sv */
// ----------------------------------------------------------------------------
// hdt_pkg
// shared widths, codes and the table entry layout
// ----------------------------------------------------------------------------
package hdt_pkg;

  localparam int unsigned DEPTH_DEF = 32;

  localparam int unsigned ID_W    = 64;
  localparam int unsigned PROC_W  = 31;
  localparam int unsigned NOW_W   = 48;
  localparam int unsigned DL_W    = 49;
  localparam int unsigned TMO_W   = 32;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PADDR_W = 3;

  localparam logic [TMO_W-1:0] TMO_RST = 32'd30000;

  // register index, taken from paddr[2]
  localparam logic REG_TMO = 1'b0;

  typedef enum logic [1:0] {
    FUNC_TRACK   = 2'd0,
    FUNC_REFRESH = 2'd1,
    FUNC_EXIT    = 2'd2,
    FUNC_SCAN    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PROC_W-1:0] proc;
    logic [DL_W-1:0]   deadline;
    logic              exiting;
  } slot_t;

endpackage

/* src/hdt_if.sv */
// ----------------------------------------------------------------------------
// hdt request and result channels
// valid/ready channels carrying the request and result payloads
// ----------------------------------------------------------------------------
interface hdt_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  func;
  logic [hdt_pkg::ID_W-1:0]    entry_id;
  logic [hdt_pkg::PROC_W-1:0]  proc_num;
  logic [hdt_pkg::NOW_W-1:0]   now_time;

  modport source (output valid, func, entry_id, proc_num, now_time, input ready);
  modport sink   (input valid, func, entry_id, proc_num, now_time, output ready);
endinterface

interface hdt_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [1:0]                  status;
  logic [hdt_pkg::ID_W-1:0]    out_id;
  logic [hdt_pkg::PROC_W-1:0]  out_proc;
  logic                        last;

  modport source (output valid, kind, status, out_id, out_proc, last, input ready);
  modport sink   (input valid, kind, status, out_id, out_proc, last, output ready);
endinterface

/* src/heartbeat_deadline_table_core.sv */
// ----------------------------------------------------------------------------
// heartbeat_deadline_table_core
// per-entry watchdog table: track, refresh, mark exiting and timeout scan
// ----------------------------------------------------------------------------
// usage:
//   in_req carries one request (func, entry_id, proc_num, now_time); out_rsp
//   carries results. track, refresh and mark-exit give one result; scan gives
//   one report per timed-out live entry in index order, then a done result.
//   last marks the final result of each request. the timeout register sits
//   at byte address 0 of the apb port; the user writes it only while idle, the block itself does not enforce this.
// request flow:
//   one request at a time. track: the result passes through the S_FIN state
//   into the output register, and the next request is taken back in S_IDLE.
//   refresh, mark-exit and scan walk the table memory one entry per cycle
//   while no report is held off, through the single read port of the entry
//   memory.
// reset:
//   synchronous active-low reset empties the table (fill count to zero) and
//   loads the timeout with 30000; the entry memory itself is not cleared.
// stalls:
//   results sit in an output register; while the receiver holds off, a scan
//   pauses on the next timed-out entry and the final result waits in S_FIN.
// ----------------------------------------------------------------------------
module heartbeat_deadline_table_core #(
  parameter int unsigned DEPTH = hdt_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  hdt_in_if.sink                        in_req,
  hdt_out_if.source                     out_rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hdt_pkg::PADDR_W-1:0]   paddr,
  input  logic [hdt_pkg::DATA_W-1:0]    pwdata,
  output logic [hdt_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  // fill count holds 0..DEPTH, entry address holds 0..DEPTH-1
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } state_t;

  // control and request registers
  state_t                           state_r;
  hdt_pkg::func_t                   func_r;
  hdt_pkg::status_t                 status_r;
  logic [hdt_pkg::ID_W-1:0]         id_r;
  logic [hdt_pkg::NOW_W-1:0]        now_r;
  logic [hdt_pkg::DL_W-1:0]         dl_r;
  logic [CW-1:0]                    used_r;
  logic [CW-1:0]                    ptr_r;
  logic                             dv_r;
  logic [AW-1:0]                    didx_r;
  logic [hdt_pkg::TMO_W-1:0]        tmo_r;

  // output register
  logic                             ovalid_r;
  logic                             okind_r;
  hdt_pkg::status_t                 ostatus_r;
  logic [hdt_pkg::ID_W-1:0]         oid_r;
  logic [hdt_pkg::PROC_W-1:0]       oproc_r;
  logic                             olast_r;

  // entry memory, one read port with registered data
  hdt_pkg::slot_t                   mem [DEPTH];
  hdt_pkg::slot_t                   rd_r;

  logic                             in_acc;
  hdt_pkg::func_t                   in_func;
  logic [hdt_pkg::DL_W-1:0]         dl_in;
  logic                             full;
  logic                             out_busy;
  logic                             scan_hit;
  logic                             id_hit;
  logic                             chk_scan;
  logic                             chk_look;
  logic                             stall;
  logic                             more;
  logic                             rd_en;
  logic                             wr_en;
  logic [AW-1:0]                    wr_addr;
  hdt_pkg::slot_t                   wr_data;
  logic                             cfg_wr;

  assign in_req.ready = rst_n && (state_r == S_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign in_func      = hdt_pkg::func_t'(in_req.func);

  // deadline never wraps: 48-bit time plus 32-bit timeout fits in 49 bits
  assign dl_in = hdt_pkg::DL_W'({1'b0, in_req.now_time}) + hdt_pkg::DL_W'(tmo_r);

  assign full     = (used_r == CW'(DEPTH));
  assign out_busy = ovalid_r && !out_rsp.ready;

  // check stage of the walk, one entry of read data per cycle unless a report stalls
  assign scan_hit = !rd_r.exiting && ({1'b0, now_r} > rd_r.deadline);
  assign id_hit   = (rd_r.id == id_r);
  assign chk_scan = (state_r == S_WALK) && dv_r && (func_r == hdt_pkg::FUNC_SCAN);
  assign chk_look = (state_r == S_WALK) && dv_r && (func_r != hdt_pkg::FUNC_SCAN);

  // a report that cannot leave holds the whole walk, read data included
  assign stall = chk_scan && scan_hit && out_busy;
  assign more  = (ptr_r < used_r);
  assign rd_en = (state_r == S_WALK) && !stall && more;

  // write port: append on track, write back on a lookup hit
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = used_r[AW-1:0];
    wr_data = rd_r;
    if (in_acc && (in_func == hdt_pkg::FUNC_TRACK) && !full) begin
      wr_en            = 1'b1;
      wr_addr          = used_r[AW-1:0];
      wr_data.id       = in_req.entry_id;
      wr_data.proc     = in_req.proc_num;
      wr_data.deadline = dl_in;
      wr_data.exiting  = 1'b0;
    end else if (chk_look && id_hit) begin
      wr_en   = 1'b1;
      wr_addr = didx_r;
      if (func_r == hdt_pkg::FUNC_REFRESH) begin
        wr_data.deadline = dl_r;
      end else begin
        wr_data.exiting = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[ptr_r[AW-1:0]];
    end
  end

  // apb register access
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == hdt_pkg::REG_TMO) ? tmo_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      used_r   <= '0;
      dv_r     <= 1'b0;
      ovalid_r <= 1'b0;
      tmo_r    <= hdt_pkg::TMO_RST;
    end else begin
      if (cfg_wr && (paddr[2] == hdt_pkg::REG_TMO)) begin
        tmo_r <= pwdata;
      end

      if (out_rsp.ready) begin
        ovalid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            func_r <= in_func;
            id_r   <= in_req.entry_id;
            now_r  <= in_req.now_time;
            dl_r   <= dl_in;
            ptr_r  <= '0;
            dv_r   <= 1'b0;
            if (in_func == hdt_pkg::FUNC_TRACK) begin
              // append at the fill count, or report a full table
              status_r <= full ? hdt_pkg::STAT_FULL : hdt_pkg::STAT_OK;
              if (!full) begin
                used_r <= used_r + CW'(1);
              end
              state_r <= S_FIN;
            end else begin
              status_r <= (in_func == hdt_pkg::FUNC_SCAN) ?
                          hdt_pkg::STAT_OK : hdt_pkg::STAT_NOT_FOUND;
              state_r  <= S_WALK;
            end
          end
        end

        S_WALK: begin
          if (!stall) begin
            // issue the next read while checking the previous entry
            if (more) begin
              ptr_r  <= ptr_r + CW'(1);
              didx_r <= ptr_r[AW-1:0];
              dv_r   <= 1'b1;
            end else begin
              dv_r    <= 1'b0;
              state_r <= S_FIN;
            end

            if (chk_scan && scan_hit) begin
              ovalid_r  <= 1'b1;
              okind_r   <= hdt_pkg::KIND_REPORT;
              ostatus_r <= hdt_pkg::STAT_OK;
              oid_r     <= rd_r.id;
              oproc_r   <= rd_r.proc;
              olast_r   <= 1'b0;
            end

            // lowest-index match ends the lookup, written back above
            if (chk_look && id_hit) begin
              status_r <= hdt_pkg::STAT_OK;
              dv_r     <= 1'b0;
              state_r  <= S_FIN;
            end
          end
        end

        S_FIN: begin
          if (!out_busy) begin
            ovalid_r  <= 1'b1;
            okind_r   <= hdt_pkg::KIND_ACK;
            ostatus_r <= status_r;
            oid_r     <= '0;
            oproc_r   <= '0;
            olast_r   <= 1'b1;
            state_r   <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_rsp.valid    = ovalid_r;
  assign out_rsp.kind     = okind_r;
  assign out_rsp.status   = ostatus_r;
  assign out_rsp.out_id   = oid_r;
  assign out_rsp.out_proc = oproc_r;
  assign out_rsp.last     = olast_r;

endmodule

/* src/hdt_chk.sv */
// ----------------------------------------------------------------------------
// hdt_chk
// port-level checks on the heartbeat deadline table, bound to the top level
// ----------------------------------------------------------------------------
`include "heartbeat_deadline_table_core_defines.svh"

module hdt_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_kind,
  input logic [1:0]                    out_status,
  input logic [hdt_pkg::ID_W-1:0]      out_id,
  input logic [hdt_pkg::PROC_W-1:0]    out_proc,
  input logic                          out_last
);

  // a stalled result stays put
  `HDT_ASSERT_RST(a_out_hold, clk, rst_n, (out_valid && !out_ready |=> out_valid && $stable({out_kind, out_status, out_id, out_proc, out_last})))

  // one request in flight: ready drops right after an accept
  `HDT_ASSERT_RST(a_one_request, clk, rst_n, (in_valid && in_ready |=> !in_ready))

  // reports never close a request, every acknowledge does
  `HDT_ASSERT_RST(a_last_on_ack, clk, rst_n, (out_valid |-> (out_last == (out_kind != hdt_pkg::KIND_REPORT))))

  // reports carry an ok status
  `HDT_ASSERT_RST(a_report_ok, clk, rst_n, (out_valid && (out_kind == hdt_pkg::KIND_REPORT) |-> (out_status == hdt_pkg::STAT_OK)))

  // reset drops any pending result
  `HDT_ASSERT_ALWAYS(a_reset_clear, clk, (!rst_n |=> !out_valid))

endmodule

bind heartbeat_deadline_table_core hdt_chk u_hdt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .out_kind   (out_rsp.kind),
  .out_status (out_rsp.status),
  .out_id     (out_rsp.out_id),
  .out_proc   (out_rsp.out_proc),
  .out_last   (out_rsp.last)
);

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// heartbeat deadline table testbench
// drives track, refresh, mark-exit and scan requests with random gaps and
// result stalls, predicts every result from a private copy of the table and
// timeout, and checks each result field by field in arrival order
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TBL_DEPTH   = hdt_pkg::DEPTH_DEF;
  localparam int          STALL_LIMIT = 2000;          // cycles with no handshake
  localparam int          SETTLE_CYC  = TBL_DEPTH + 8; // longest walk plus margin

  // register map: index from paddr[2]
  localparam logic [hdt_pkg::PADDR_W-1:0] ADDR_TMO    = 3'd0;
  localparam logic [hdt_pkg::PADDR_W-1:0] ADDR_UNUSED = 3'd4;

  typedef struct packed {
    hdt_pkg::func_t             func;
    logic [hdt_pkg::ID_W-1:0]   id;
    logic [hdt_pkg::PROC_W-1:0] proc;
    logic [hdt_pkg::NOW_W-1:0]  now;
  } req_t;

  typedef struct packed {
    logic                       kind;
    hdt_pkg::status_t           status;
    logic [hdt_pkg::ID_W-1:0]   id;
    logic [hdt_pkg::PROC_W-1:0] proc;
    logic                       last;
  } rsp_t;

  logic clk;
  logic rst_n;

  // apb side
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [hdt_pkg::PADDR_W-1:0] paddr;
  logic [hdt_pkg::DATA_W-1:0]  pwdata;
  logic [hdt_pkg::DATA_W-1:0]  prdata;
  logic                        pready;

  hdt_in_if  in_req_if ();
  hdt_out_if out_rsp_if ();

  heartbeat_deadline_table_core #(
    .DEPTH(TBL_DEPTH)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req_if),
    .out_rsp(out_rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // --------------------------------------------------------------------------
  // predicted table contents and timeout register
  // --------------------------------------------------------------------------
  hdt_pkg::slot_t             tbl_entry [TBL_DEPTH];
  int unsigned                tbl_fill;
  logic [hdt_pkg::TMO_W-1:0]  tbl_tmo;

  req_t req_backlog[$];   // requests waiting for the driver
  rsp_t rsp_expected[$];  // results predicted but not yet seen
  int   err_cnt;

  // generator bookkeeping
  logic [hdt_pkg::ID_W-1:0]  known_ids[$];  // ids that made it into the table
  int unsigned               tracks_queued;
  logic [hdt_pkg::NOW_W-1:0] clock_ms;

  // driver state
  req_t live_req;
  bit   req_live;
  int   hold_cnt;
  bit   drv_quiet;

  // monitor state
  int   stall_cnt;
  bit   mon_quiet;

  int   idle_cyc;

  // --------------------------------------------------------------------------
  // apply one accepted request to the predicted table and queue its results
  // --------------------------------------------------------------------------
  task automatic table_apply(input req_t r);
    rsp_t                     rsp;
    logic [hdt_pkg::DL_W-1:0] dl;
    int                       hit;
    int                       i;
    // deadline is one bit wider than now, so it never wraps
    dl  = {1'b0, r.now} + hdt_pkg::DL_W'(tbl_tmo);
    rsp = '{kind: hdt_pkg::KIND_ACK, status: hdt_pkg::STAT_OK, id: '0, proc: '0,
            last: 1'b1};
    hit = -1;
    case (r.func)
      hdt_pkg::FUNC_TRACK: begin
        if (tbl_fill >= TBL_DEPTH) begin
          rsp.status = hdt_pkg::STAT_FULL;
        end else begin
          tbl_entry[tbl_fill] = '{id: r.id, proc: r.proc, deadline: dl,
                                  exiting: 1'b0};
          tbl_fill++;
        end
      end
      hdt_pkg::FUNC_REFRESH, hdt_pkg::FUNC_EXIT: begin
        // walk downward so the lowest matching index wins
        for (i = int'(tbl_fill) - 1; i >= 0; i--) begin
          if (tbl_entry[i].id == r.id) hit = i;
        end
        if (hit < 0) begin
          rsp.status = hdt_pkg::STAT_NOT_FOUND;
        end else if (r.func == hdt_pkg::FUNC_REFRESH) begin
          tbl_entry[hit].deadline = dl;
        end else begin
          tbl_entry[hit].exiting = 1'b1;
        end
      end
      default: begin
        // scan: live entries strictly past their deadline, in index order
        for (i = 0; i < int'(tbl_fill); i++) begin
          if (!tbl_entry[i].exiting && {1'b0, r.now} > tbl_entry[i].deadline) begin
            rsp_expected.push_back('{kind: hdt_pkg::KIND_REPORT,
                                     status: hdt_pkg::STAT_OK,
                                     id: tbl_entry[i].id, proc: tbl_entry[i].proc,
                                     last: 1'b0});
          end
        end
      end
    endcase
    rsp_expected.push_back(rsp);
  endtask

  function automatic int draw_pause(inout bit quiet);
    // flip between stretches with no pauses and stretches with random ones
    if ($urandom_range(0, 15) == 0) quiet = !quiet;
    return quiet ? 0 : int'($urandom_range(0, 10));
  endfunction

  function automatic void check_field(string name, logic [hdt_pkg::ID_W-1:0] exp_v,
                                      logic [hdt_pkg::ID_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // request generation
  // --------------------------------------------------------------------------
  task automatic queue_request(input hdt_pkg::func_t f,
                               input logic [hdt_pkg::ID_W-1:0] id,
                               input logic [hdt_pkg::PROC_W-1:0] proc,
                               input logic [hdt_pkg::NOW_W-1:0] now);
    if (f == hdt_pkg::FUNC_TRACK) begin
      if (tracks_queued < TBL_DEPTH) known_ids.push_back(id);
      tracks_queued++;
    end
    req_backlog.push_back('{func: f, id: id, proc: proc, now: now});
  endtask

  function automatic logic [hdt_pkg::ID_W-1:0] pick_id();
    // mostly ids already in the table, sometimes a fresh one that misses
    if (known_ids.size() != 0 && $urandom_range(0, 4) != 0)
      return known_ids[$urandom_range(0, known_ids.size() - 1)];
    return {$urandom, $urandom};
  endfunction

  task automatic queue_random();
    logic [hdt_pkg::ID_W-1:0]   rid;
    logic [hdt_pkg::PROC_W-1:0] rproc;
    logic [63:0]                off;
    int unsigned                sel;
    rid   = {$urandom, $urandom};
    rproc = hdt_pkg::PROC_W'($urandom);
    sel   = $urandom_range(0, 99);
    // time moves forward so older entries drift past their deadlines
    clock_ms = clock_ms + hdt_pkg::NOW_W'($urandom_range(0, tbl_tmo / 2 + 3));
    if (sel < 30) begin
      queue_request(hdt_pkg::FUNC_TRACK, rid, rproc, clock_ms);
    end else if (sel < 55) begin
      queue_request(hdt_pkg::FUNC_REFRESH, pick_id(), rproc, clock_ms);
    end else if (sel < 67) begin
      queue_request(hdt_pkg::FUNC_EXIT, pick_id(), rproc, clock_ms);
    end else if (sel < 92) begin
      // scan near the live deadlines: up to two timeouts past the clock
      off = ((64'(tbl_tmo) * 64'($urandom_range(0, 256))) >> 7) + $urandom_range(0, 3);
      queue_request(hdt_pkg::FUNC_SCAN, rid, rproc,
                    hdt_pkg::NOW_W'(64'(clock_ms) + off));
    end else begin
      // noise: any function, any time
      queue_request(hdt_pkg::func_t'($urandom_range(0, 3)), rid, rproc,
                    hdt_pkg::NOW_W'({$urandom, $urandom}));
    end
  endtask

  // --------------------------------------------------------------------------
  // apb register write: setup then access, register taken when pready is high
  // --------------------------------------------------------------------------
  task automatic reg_write(input logic [hdt_pkg::PADDR_W-1:0] addr,
                           input logic [hdt_pkg::DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // only index 0 exists, the other index is dropped
    if (addr[2] == hdt_pkg::REG_TMO) tbl_tmo = val;
  endtask

  // hold off until every request is through and every result is back
  task automatic wait_idle();
    do @(posedge clk);
    while (req_backlog.size() != 0 || req_live || rsp_expected.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // request driver: one request at a time from the backlog, random gaps
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_req_if.valid <= 1'b0;
      req_live  = 1'b0;
      hold_cnt  = 0;
    end else begin
      if (in_req_if.valid && in_req_if.ready) begin
        // predict at the accepting edge, results come later
        table_apply(live_req);
        req_live = 1'b0;
        hold_cnt = draw_pause(drv_quiet);
      end
      if (!req_live) begin
        if (hold_cnt > 0) begin
          hold_cnt--;
        end else if (req_backlog.size() != 0) begin
          live_req = req_backlog.pop_front();
          req_live = 1'b1;
        end
      end
      // single assignment per edge keeps valid high across back-to-back requests
      in_req_if.valid    <= req_live;
      in_req_if.func     <= live_req.func;
      in_req_if.entry_id <= live_req.id;
      in_req_if.proc_num <= live_req.proc;
      in_req_if.now_time <= live_req.now;
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: compares against the oldest prediction, random stalls
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rsp_t exp_rsp;
    bit   rdy;
    if (!rst_n) begin
      out_rsp_if.ready <= 1'b0;
      stall_cnt = 0;
    end else begin
      if (out_rsp_if.valid && out_rsp_if.ready) begin
        if (rsp_expected.size() == 0) begin
          $error("result with nothing expected: kind %0d status %0d id 0x%0h last %0d",
                 out_rsp_if.kind, out_rsp_if.status, out_rsp_if.out_id, out_rsp_if.last);
          err_cnt++;
        end else begin
          exp_rsp = rsp_expected.pop_front();
          check_field("kind", hdt_pkg::ID_W'(exp_rsp.kind),
                      hdt_pkg::ID_W'(out_rsp_if.kind));
          check_field("status", hdt_pkg::ID_W'(exp_rsp.status),
                      hdt_pkg::ID_W'(out_rsp_if.status));
          check_field("out_id", exp_rsp.id, out_rsp_if.out_id);
          check_field("out_proc", hdt_pkg::ID_W'(exp_rsp.proc),
                      hdt_pkg::ID_W'(out_rsp_if.out_proc));
          check_field("last", hdt_pkg::ID_W'(exp_rsp.last),
                      hdt_pkg::ID_W'(out_rsp_if.last));
        end
        stall_cnt = draw_pause(mon_quiet);
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_rsp_if.ready <= rdy;
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without any handshake on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_req_if.valid && in_req_if.ready) || (out_rsp_if.valid && out_rsp_if.ready)) begin
      idle_cyc = 0;
    end else begin
      idle_cyc++;
    end
    if (idle_cyc >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [hdt_pkg::ID_W-1:0] dup_id;
    // every block input known from time zero
    rst_n              = 1'b0;
    in_req_if.valid    = 1'b0;
    in_req_if.func     = hdt_pkg::FUNC_SCAN;
    in_req_if.entry_id = '0;
    in_req_if.proc_num = '0;
    in_req_if.now_time = '0;
    out_rsp_if.ready   = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    err_cnt            = 0;
    idle_cyc           = 0;
    tracks_queued      = 0;
    tbl_fill           = 0;
    tbl_tmo            = hdt_pkg::TMO_RST;
    clock_ms           = '0;
    live_req           = '0;
    drv_quiet          = 1'b0;
    mon_quiet          = 1'b0;
    dup_id             = 64'h5A5A_0F0F_C3C3_9696;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under the reset timeout of 30000
    // empty table: scan gives only done, lookups miss
    queue_request(hdt_pkg::FUNC_SCAN,    '0,     '0, '0);
    queue_request(hdt_pkg::FUNC_REFRESH, dup_id, '0, 48'd10);
    queue_request(hdt_pkg::FUNC_EXIT,    dup_id, '0, 48'd10);
    // field extremes on track
    queue_request(hdt_pkg::FUNC_TRACK, '1, '1, '1);
    queue_request(hdt_pkg::FUNC_TRACK, '0, '0, '0);
    // duplicate ids: refresh and mark-exit hit the lower slot only
    queue_request(hdt_pkg::FUNC_TRACK,   dup_id, 31'd1, 48'd1000);
    queue_request(hdt_pkg::FUNC_TRACK,   dup_id, 31'd2, 48'd50000);
    queue_request(hdt_pkg::FUNC_REFRESH, dup_id, '1,    48'd40000);
    // deadline boundary: a report only once now is strictly past it
    queue_request(hdt_pkg::FUNC_SCAN, '1, '1, 48'd30000);
    queue_request(hdt_pkg::FUNC_SCAN, '1, '1, 48'd30001);
    queue_request(hdt_pkg::FUNC_EXIT, dup_id, '0, 48'd60000);
    queue_request(hdt_pkg::FUNC_SCAN, '0, '0, 48'd100000);
    queue_request(hdt_pkg::FUNC_EXIT, dup_id, '0, 48'd100001);
    queue_request(hdt_pkg::FUNC_REFRESH, 64'hDEAD_0000_0000_0001, '0, 48'd100002);
    queue_request(hdt_pkg::FUNC_SCAN, '0, '0, '1);
    queue_request(hdt_pkg::FUNC_TRACK, 64'h8000_0000_0000_0001, 31'h4000_0001,
                  48'h8000_0000_0001);
    wait_idle();

    // shortest timeout
    reg_write(ADDR_TMO, 32'd1);
    clock_ms = 48'd200000;
    repeat (30) queue_random();
    wait_idle();

    // longest timeout: the widest deadline must not wrap
    reg_write(ADDR_TMO, 32'hFFFF_FFFF);
    queue_request(hdt_pkg::FUNC_TRACK, 64'h0123_4567_89AB_CDEF, 31'h2AAA_AAAA, '1);
    queue_request(hdt_pkg::FUNC_SCAN,  '0, '0, '1);
    clock_ms = hdt_pkg::NOW_W'({$urandom_range(0, 255), $urandom});
    repeat (30) queue_random();
    wait_idle();

    // a write to the unmapped index must leave the timeout alone
    reg_write(ADDR_UNUSED, 32'd7);
    queue_request(hdt_pkg::FUNC_TRACK, 64'h0000_FFFF_0000_FFFF, 31'h1555_5555, clock_ms);
    wait_idle();

    // random middle timeout, then drive the table into the full state
    reg_write(ADDR_TMO, $urandom_range(50, 5000000));
    repeat (20) queue_random();
    while (tracks_queued < TBL_DEPTH + 3)
      queue_request(hdt_pkg::FUNC_TRACK, {$urandom, $urandom},
                    hdt_pkg::PROC_W'($urandom), clock_ms);
    queue_request(hdt_pkg::FUNC_SCAN, '0, '0, '1);
    wait_idle();

    if (err_cnt == 0 && rsp_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
